### design/shift_register_output_expander_defines.svh
// Assertion macros for the shift register output expander checks.
`ifndef SHIFT_REGISTER_OUTPUT_EXPANDER_DEFINES_SVH
`define SHIFT_REGISTER_OUTPUT_EXPANDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SROE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SROE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sroe_pkg.sv
// Shared types and constants of the shift register output expander.
package sroe_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_PUSH  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_MSB_FIRST   = 2'd0,
    CFG_CHIP_ORDER  = 2'd1,
    CFG_AUTO_PUSH   = 2'd2,
    CFG_PIN_DELAY   = 2'd3
  } cfg_idx_t;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DELAY_W = 16;

  localparam logic               RST_MSB_FIRST  = 1'b1;
  localparam logic               RST_CHIP_ORDER = 1'b0;
  localparam logic               RST_AUTO_PUSH  = 1'b1;
  localparam logic [DELAY_W-1:0] RST_PIN_DELAY  = 16'd10;

  localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

### design/shift_register_output_expander.sv
// Shift register output expander: per-chip byte cache and serial push sequencer.
//
// Drives a chain of CHIPS 8-bit serial-in latches. The input channel
// (in_valid/in_stall) takes one request per beat: masked write, masked
// read, push of the cache, or clear and push. The result channel
// (out_valid/out_stall) gives one beat per shifted bit, CHIPS*8 beats for
// a push, with latch_after and last on the final bit; a read, an error or
// a write without auto push gives a single beat.
// A single-beat request goes through the S_SINGLE state into the output
// register. A push loads each chip's byte from the cache in S_LOAD, then
// runs each bit through the bit timer (S_WAIT, counting down pin_delay)
// and the one shared shift register before S_EMIT sends it.
// The block takes one request at a time; in_stall is high until the last
// beat sits in the output register.
// A stalled receiver holds the output register, and the sequencer waits.
// Reset clears the cache and loads register defaults (bit 7 first, highest
// chip first, auto push on, pin_delay 10). cfg_ready is always high.
module shift_register_output_expander #(
  parameter int CHIPS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  sroe_pkg::cfg_idx_t       cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  sroe_pkg::func_t          in_func,
  input  logic [7:0]               in_chip_index,
  input  logic [7:0]               in_pin_mask,
  input  logic                     in_level,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_shift_valid,
  output logic                     out_serial_bit,
  output logic                     out_latch_after,
  output logic [7:0]               out_read_bits,
  output logic                     out_status,
  output logic                     out_last
);
  import sroe_pkg::*;

  localparam int CW = (CHIPS > 1) ? $clog2(CHIPS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_LOAD,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t              state_r;
  logic [BYTE_W-1:0]   cache_r [CHIPS];
  logic                msb_first_r;
  logic                chip_order_r;
  logic                auto_push_r;
  logic [DELAY_W-1:0]  pin_delay_r;
  logic [DELAY_W-1:0]  delay_r;
  logic [CW-1:0]       chip_r;
  logic [2:0]          bit_r;
  logic [BYTE_W-1:0]   shreg_r;
  logic [BYTE_W-1:0]   pend_read_r;
  logic                pend_status_r;

  logic                out_valid_r;
  logic                out_shift_valid_r;
  logic                out_serial_bit_r;
  logic                out_latch_after_r;
  logic [BYTE_W-1:0]   out_read_bits_r;
  logic                out_status_r;
  logic                out_last_r;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic                in_range;
  logic [CW-1:0]       chip_sel;
  logic [CW-1:0]       rd_idx;
  logic [BYTE_W-1:0]   rd_byte;
  logic [BYTE_W-1:0]   wr_byte;
  logic                final_chip;
  logic                cur_bit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = ((state_r == S_SINGLE) || (state_r == S_EMIT)) && out_free;
  assign in_range  = (in_chip_index < 8'(CHIPS));

  assign chip_sel   = chip_order_r ? chip_r : (CW'(CHIPS - 1) - chip_r);
  assign rd_idx     = (state_r == S_IDLE) ? in_chip_index[CW-1:0] : chip_sel;
  assign rd_byte    = cache_r[rd_idx];
  assign wr_byte    = in_level ? (rd_byte | in_pin_mask) : (rd_byte & ~in_pin_mask);
  assign final_chip = (chip_r == CW'(CHIPS - 1));
  assign cur_bit    = msb_first_r ? shreg_r[BYTE_W-1] : shreg_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      msb_first_r  <= RST_MSB_FIRST;
      chip_order_r <= RST_CHIP_ORDER;
      auto_push_r  <= RST_AUTO_PUSH;
      pin_delay_r  <= RST_PIN_DELAY;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < CHIPS; i++) begin
        cache_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MSB_FIRST:  msb_first_r  <= cfg_data[0];
          CFG_CHIP_ORDER: chip_order_r <= cfg_data[0];
          CFG_AUTO_PUSH:  auto_push_r  <= cfg_data[0];
          CFG_PIN_DELAY:  pin_delay_r  <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            chip_r        <= '0;
            bit_r         <= '0;
            unique case (in_func)
              FUNC_PUSH: begin
                state_r <= S_LOAD;
              end
              FUNC_CLEAR: begin
                for (int i = 0; i < CHIPS; i++) begin
                  cache_r[i] <= '0;
                end
                state_r <= S_LOAD;
              end
              FUNC_READ: begin
                pend_status_r <= !in_range;
                pend_read_r   <= in_range ? (rd_byte & in_pin_mask) : '0;
                state_r       <= S_SINGLE;
              end
              FUNC_WRITE: begin
                pend_read_r <= '0;
                if (!in_range) begin
                  pend_status_r <= 1'b1;
                  state_r       <= S_SINGLE;
                end else begin
                  pend_status_r <= 1'b0;
                  cache_r[in_chip_index[CW-1:0]] <= wr_byte;
                  state_r <= auto_push_r ? S_LOAD : S_SINGLE;
                end
              end
              default: ;
            endcase
          end
        end
        S_SINGLE: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_shift_valid_r <= 1'b0;
            out_serial_bit_r  <= 1'b0;
            out_latch_after_r <= 1'b0;
            out_read_bits_r   <= pend_read_r;
            out_status_r      <= pend_status_r;
            out_last_r        <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        S_LOAD: begin
          shreg_r <= rd_byte;
          delay_r <= pin_delay_r;
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (delay_r == '0) begin
            state_r <= S_EMIT;
          end else begin
            delay_r <= delay_r - 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_shift_valid_r <= 1'b1;
            out_serial_bit_r  <= cur_bit;
            out_latch_after_r <= final_chip && (bit_r == LAST_BIT);
            out_read_bits_r   <= '0;
            out_status_r      <= 1'b0;
            out_last_r        <= final_chip && (bit_r == LAST_BIT);
            shreg_r <= msb_first_r ? {shreg_r[BYTE_W-2:0], 1'b0}
                                   : {1'b0, shreg_r[BYTE_W-1:1]};
            if (bit_r == LAST_BIT) begin
              bit_r <= '0;
              if (final_chip) begin
                state_r <= S_IDLE;
              end else begin
                chip_r  <= chip_r + 1'b1;
                state_r <= S_LOAD;
              end
            end else begin
              bit_r   <= bit_r + 1'b1;
              delay_r <= pin_delay_r;
              state_r <= S_WAIT;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_shift_valid = out_shift_valid_r;
  assign out_serial_bit  = out_serial_bit_r;
  assign out_latch_after = out_latch_after_r;
  assign out_read_bits   = out_read_bits_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

endmodule

### design/sroe_checker.sv
// Port-level checks of the shift register output expander, bound to the top level.
`include "shift_register_output_expander_defines.svh"

module sroe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_shift_valid,
  input logic        out_serial_bit,
  input logic        out_latch_after,
  input logic [7:0]  out_read_bits,
  input logic        out_status,
  input logic        out_last
);

  `SROE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_serial_bit) && $stable(out_shift_valid) && $stable(out_last), "stalled result beat changed")

  `SROE_ASSERT_NOW(a_latch_final, out_valid && out_latch_after, out_shift_valid && out_last, "latch pulse off a final shifted bit")

  `SROE_ASSERT_NOW(a_single_last, out_valid && !out_shift_valid, out_last && !out_latch_after && !out_serial_bit, "single-beat result not marked last")

  `SROE_ASSERT_NOW(a_error_clean, out_valid && out_status, !out_shift_valid && (out_read_bits == 8'd0), "error result carries data")

endmodule

bind shift_register_output_expander sroe_checker u_sroe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_shift_valid (out_shift_valid),
  .out_serial_bit  (out_serial_bit),
  .out_latch_after (out_latch_after),
  .out_read_bits   (out_read_bits),
  .out_status      (out_status),
  .out_last        (out_last)
);

### bench/shift_register_output_expander_tb.sv
// Self-checking testbench for the shift register output expander: directed and random requests.
module shift_register_output_expander_tb;
  import sroe_pkg::*;

  localparam int NUM_CHIPS = 4;
  localparam int CHIP_W    = $clog2(NUM_CHIPS);

  typedef struct packed {
    logic       shift_valid;
    logic       serial_bit;
    logic       latch_after;
    logic [7:0] read_bits;
    logic       status;
    logic       last;
  } beat_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_MSB_FIRST;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  func_t       in_func = FUNC_WRITE;
  logic [7:0]  in_chip_index = '0;
  logic [7:0]  in_pin_mask = '0;
  logic        in_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_shift_valid;
  logic        out_serial_bit;
  logic        out_latch_after;
  logic [7:0]  out_read_bits;
  logic        out_status;
  logic        out_last;

  logic [7:0] cache_model [NUM_CHIPS];
  logic       msb_first_model = RST_MSB_FIRST;
  logic       chip_order_model = RST_CHIP_ORDER;
  logic       auto_push_model = RST_AUTO_PUSH;

  beat_t expected_beats [$];
  int    error_count = 0;
  bit    send_idle = 1'b1;
  bit    recv_idle = 1'b1;
  bit    long_hold_req = 1'b0;
  int    long_left = 0;
  int    stall_left = 0;

  shift_register_output_expander #(.CHIPS(NUM_CHIPS)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_chip_index  (in_chip_index),
    .in_pin_mask    (in_pin_mask),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_shift_valid(out_shift_valid),
    .out_serial_bit (out_serial_bit),
    .out_latch_after(out_latch_after),
    .out_read_bits  (out_read_bits),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic void queue_single_beat(logic [7:0] rd, logic st);
    beat_t b;
    b = '{shift_valid: 1'b0, serial_bit: 1'b0, latch_after: 1'b0,
          read_bits: rd, status: st, last: 1'b1};
    expected_beats.push_back(b);
  endfunction

  function automatic void queue_chain_beats();
    beat_t             b;
    logic [CHIP_W-1:0] pos;
    logic [7:0]        sel_byte;
    logic              is_end;
    for (int c = 0; c < NUM_CHIPS; c++) begin
      pos = chip_order_model ? CHIP_W'(c) : CHIP_W'(NUM_CHIPS - 1 - c);
      sel_byte = cache_model[pos];
      for (int k = 0; k < 8; k++) begin
        is_end = (c == NUM_CHIPS - 1) && (k == 7);
        b.shift_valid = 1'b1;
        b.serial_bit = msb_first_model ? sel_byte[3'(7 - k)] : sel_byte[3'(k)];
        b.latch_after = is_end;
        b.read_bits = '0;
        b.status = 1'b0;
        b.last = is_end;
        expected_beats.push_back(b);
      end
    end
  endfunction

  function automatic void predict_request(func_t f, logic [7:0] chip, logic [7:0] mask,
                                          logic lvl);
    case (f)
      FUNC_PUSH: begin
        queue_chain_beats();
      end
      FUNC_CLEAR: begin
        foreach (cache_model[i]) cache_model[i] = '0;
        queue_chain_beats();
      end
      default: begin
        if (chip >= NUM_CHIPS) begin
          queue_single_beat(8'h00, 1'b1);
        end else if (f == FUNC_READ) begin
          queue_single_beat(cache_model[chip[CHIP_W-1:0]] & mask, 1'b0);
        end else begin
          cache_model[chip[CHIP_W-1:0]] = lvl ? (cache_model[chip[CHIP_W-1:0]] | mask)
                                              : (cache_model[chip[CHIP_W-1:0]] & ~mask);
          if (auto_push_model) queue_chain_beats();
          else queue_single_beat(8'h00, 1'b0);
        end
      end
    endcase
  endfunction

  // Receiver: random stall bursts, plus one long hold on request.
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_left = 400;
      long_hold_req = 1'b0;
    end
    if (long_left > 0) begin
      long_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_beats
    beat_t got;
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_shift_valid, out_serial_bit, out_latch_after, out_read_bits,
              out_status, out_last};
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", int'(got), 0);
      end else begin
        want = expected_beats.pop_front();
        if (got.shift_valid !== want.shift_valid)
          report_mismatch("shift_valid", int'(got.shift_valid), int'(want.shift_valid));
        if (got.serial_bit !== want.serial_bit)
          report_mismatch("serial_bit", int'(got.serial_bit), int'(want.serial_bit));
        if (got.latch_after !== want.latch_after)
          report_mismatch("latch_after", int'(got.latch_after), int'(want.latch_after));
        if (got.read_bits !== want.read_bits)
          report_mismatch("read_bits", int'(got.read_bits), int'(want.read_bits));
        if (got.status !== want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.last !== want.last)
          report_mismatch("last", int'(got.last), int'(want.last));
      end
    end
  end

  task automatic send_request(func_t f, logic [7:0] chip, logic [7:0] mask, logic lvl);
    int unsigned gap;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_chip_index <= chip;
    in_pin_mask <= mask;
    in_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(f, chip, mask, lvl);
  endtask

  task automatic send_random_request();
    func_t       f;
    logic [7:0]  chip;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) f = FUNC_WRITE;
    else if (pick < 13) f = FUNC_READ;
    else if (pick < 17) f = FUNC_PUSH;
    else f = FUNC_CLEAR;
    if ($urandom_range(0, 6) == 0) chip = 8'($urandom);
    else chip = 8'($urandom_range(0, NUM_CHIPS - 1));
    send_request(f, chip, 8'($urandom), 1'($urandom));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MSB_FIRST:  msb_first_model = data[0];
      CFG_CHIP_ORDER: chip_order_model = data[0];
      CFG_AUTO_PUSH:  auto_push_model = data[0];
      default: ;
    endcase
  endtask

  // Upper bits of the one-bit registers carry junk; only bit 0 counts.
  task automatic apply_settings(logic msb, logic order, logic ap, logic [15:0] delay);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(CFG_MSB_FIRST, {junk[15:1], msb});
    junk = 16'($urandom);
    write_reg(CFG_CHIP_ORDER, {junk[15:1], order});
    junk = 16'($urandom);
    write_reg(CFG_AUTO_PUSH, {junk[15:1], ap});
    write_reg(CFG_PIN_DELAY, delay);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_push();
    send_request(FUNC_PUSH, 8'h00, 8'h00, 1'b0);
    send_request(FUNC_WRITE, 8'h00, 8'hFF, 1'b1);
    wait_results_done();
  endtask

  task automatic test_masked_writes();
    send_request(FUNC_WRITE, 8'd3, 8'h81, 1'b1);
    send_request(FUNC_WRITE, 8'd3, 8'h01, 1'b0);
    send_request(FUNC_WRITE, 8'd1, 8'h00, 1'b1);
    send_request(FUNC_WRITE, 8'd2, 8'h5A, 1'b1);
    send_request(FUNC_WRITE, 8'd0, 8'h0F, 1'b0);
    wait_results_done();
  endtask

  task automatic test_masked_reads();
    send_request(FUNC_READ, 8'd0, 8'hFF, 1'b1);
    send_request(FUNC_READ, 8'd3, 8'hF0, 1'b0);
    send_request(FUNC_READ, 8'd2, 8'h00, 1'b1);
    wait_results_done();
  endtask

  task automatic test_bad_chip();
    send_request(FUNC_WRITE, 8'd4, 8'hFF, 1'b1);
    send_request(FUNC_READ, 8'hFF, 8'hFF, 1'b0);
    send_request(FUNC_WRITE, 8'hFF, 8'hAA, 1'b0);
    wait_results_done();
  endtask

  task automatic test_ignored_fields();
    send_request(FUNC_PUSH, 8'hFF, 8'hFF, 1'b1);
    send_request(FUNC_CLEAR, 8'hA5, 8'h3C, 1'b1);
    wait_results_done();
  endtask

  task automatic test_manual_push();
    apply_settings(1'b0, 1'b1, 1'b0, 16'd0);
    send_request(FUNC_WRITE, 8'd2, 8'hA5, 1'b1);
    send_request(FUNC_WRITE, 8'd1, 8'h3C, 1'b1);
    send_request(FUNC_PUSH, 8'd0, 8'h00, 1'b0);
    send_request(FUNC_READ, 8'd2, 8'hFF, 1'b0);
    wait_results_done();
  endtask

  // Widest pin delay, with no request that shifts.
  task automatic test_slow_pins();
    apply_settings(1'b1, 1'b0, 1'b0, 16'hFFFF);
    send_request(FUNC_WRITE, 8'd0, 8'hC3, 1'b1);
    send_request(FUNC_READ, 8'd0, 8'hFF, 1'b0);
    send_request(FUNC_READ, 8'd7, 8'h01, 1'b1);
    wait_results_done();
  endtask

  task automatic test_random_phases();
    logic [2:0] mode;
    for (int p = 0; p < 8; p++) begin
      mode = 3'(p);
      apply_settings(mode[0], mode[1], mode[2],
                     (p == 0) ? 16'd0 : 16'($urandom_range(0, 3)));
      repeat (30) send_random_request();
      wait_results_done();
    end
  endtask

  task automatic test_output_backpressure();
    apply_settings(1'b1, 1'b1, 1'b1, 16'd1);
    send_idle = 1'b0;
    long_hold_req = 1'b1;
    repeat (8) send_random_request();
    wait_results_done();
    send_idle = 1'b1;
  endtask

  task automatic test_sender_pause();
    apply_settings(1'b0, 1'b0, 1'b1, 16'd2);
    repeat (4) send_random_request();
    wait_results_done();
    repeat (4) send_random_request();
    wait_results_done();
  endtask

  task automatic test_final_stretch();
    apply_settings(1'($urandom), 1'($urandom), 1'b1, 16'd0);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (30) send_random_request();
    wait_results_done();
  endtask

  initial begin
    foreach (cache_model[i]) cache_model[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_push();
    test_masked_writes();
    test_masked_reads();
    test_bad_chip();
    test_ignored_fields();
    test_manual_push();
    test_slow_pins();
    test_random_phases();
    test_output_backpressure();
    test_sender_pause();
    test_final_stretch();
    repeat (50) @(posedge clk);
    if (expected_beats.size() != 0)
      report_mismatch("beats never seen", 0, expected_beats.size());
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/sroe_pkg.sv
design/shift_register_output_expander.sv
design/sroe_checker.sv
bench/shift_register_output_expander_tb.sv
